### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define OLAD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Same, on the local clk and rst_n.
`define OLAD_CHECK(label, prop) `OLAD_ASSERT(label, clk, rst_n, prop)

`endif

### hdl/olad_pkg.sv
// ---------------------------------------------------------------------------
// olad_pkg
// Types and constants for the ordered list append/delete core.
// ---------------------------------------------------------------------------
`default_nettype none

package olad_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int CMD_W    = 2;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 3;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // command codes
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LIST   = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_DONE      = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STAT_W-1:0] ST_ITEM      = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ,
    S_CHECK,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

### hdl/ordered_list_append_delete_core.sv
// ---------------------------------------------------------------------------
// ordered_list_append_delete_core
// Bounded ordered list of signed 32-bit values with append, delete-first-match
// and readout, run by a small sequencer around one entry memory and one
// 32-bit equality compare.
// ---------------------------------------------------------------------------
//
//  channel  | ports                          | word contents (low bit up)
//  ---------+--------------------------------+--------------------------------
//  input    | in_tvalid/in_tready/in_tdata   | command[1:0], value[33:2]
//  result   | out_tvalid/out_tready/out_tdata| status[2:0], item_value[34:3],
//           | out_tlast                      | tlast = last result of a command
//
//  Steps per command: accept, dispatch and emit for append, empty delete or
//  readout and the unused code; delete adds a read and a compare/move per entry
//  visited; readout: accept, dispatch, then read, check and emit per entry.
//  Reset clears only the count, sequencer and out_tvalid; entries need no clearing.
//  A stalled result word holds the sequencer in its emit step, and in_tready
//  is high only between commands.
// ---------------------------------------------------------------------------
`default_nettype none

module ordered_list_append_delete_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [olad_pkg::IN_TDATA_W-1:0]    in_tdata,   // command, value
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [olad_pkg::OUT_TDATA_W-1:0]        out_tdata,  // status, item_value
  output logic                                    out_tlast
);

  olad_pkg::state_t state_r, state_nxt;

  logic [olad_pkg::CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [olad_pkg::VAL_W-1:0]  val_r, val_nxt;
  logic [olad_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic [olad_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic                        found_r, found_nxt;

  // pending result, waiting for the output register
  logic [olad_pkg::STAT_W-1:0] res_status_r, res_status_nxt;
  logic [olad_pkg::VAL_W-1:0]  res_value_r, res_value_nxt;
  logic                        res_last_r, res_last_nxt;

  // output register
  logic                        out_valid_r, out_valid_nxt;
  logic [olad_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [olad_pkg::VAL_W-1:0]  out_value_r, out_value_nxt;
  logic                        out_last_r, out_last_nxt;

  // entry memory, one write and one registered read port
  logic [olad_pkg::VAL_W-1:0]  mem [olad_pkg::CAPACITY];
  logic [olad_pkg::VAL_W-1:0]  rd_data_r;
  logic                        mem_we;
  logic [olad_pkg::IDX_W-1:0]  mem_waddr;
  logic [olad_pkg::VAL_W-1:0]  mem_wdata;

  logic in_fire;
  logic out_free;
  logic last_one;
  logic match;

  assign in_tready = (state_r == olad_pkg::S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // current entry is the tail of the list
  assign last_one  = ((olad_pkg::CNT_W'(idx_r) + olad_pkg::CNT_W'(1)) == count_r);
  // the single compare unit
  assign match     = (rd_data_r == val_r);

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(olad_pkg::OUT_TDATA_W - olad_pkg::VAL_W - olad_pkg::STAT_W){1'b0}},
                       out_value_r, out_status_r};

  // memory: write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state_r == olad_pkg::S_READ) begin
      rd_data_r <= mem[idx_r];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      olad_pkg::S_IDLE: begin
        if (in_fire) state_nxt = olad_pkg::S_DISPATCH;
      end
      olad_pkg::S_DISPATCH: begin
        if ((cmd_r inside {olad_pkg::CMD_DELETE, olad_pkg::CMD_LIST})
            && count_r != '0) begin
          state_nxt = olad_pkg::S_READ;
        end else begin
          state_nxt = olad_pkg::S_EMIT;
        end
      end
      olad_pkg::S_READ: begin
        state_nxt = olad_pkg::S_CHECK;
      end
      olad_pkg::S_CHECK: begin
        // readout emits every entry; delete emits only at the tail
        if (cmd_r == olad_pkg::CMD_LIST || last_one) state_nxt = olad_pkg::S_EMIT;
        else                                         state_nxt = olad_pkg::S_READ;
      end
      olad_pkg::S_EMIT: begin
        if (out_free) state_nxt = res_last_r ? olad_pkg::S_IDLE : olad_pkg::S_READ;
      end
      default: state_nxt = olad_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_nxt        = cmd_r;
    val_nxt        = val_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    found_nxt      = found_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    res_last_nxt   = res_last_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r;
    mem_wdata      = rd_data_r;

    case (state_r)
      olad_pkg::S_IDLE: begin
        if (in_fire) begin
          cmd_nxt   = in_tdata[olad_pkg::CMD_W-1:0];
          val_nxt   = in_tdata[olad_pkg::CMD_W +: olad_pkg::VAL_W];
          idx_nxt   = '0;
          found_nxt = 1'b0;
        end
      end
      olad_pkg::S_DISPATCH: begin
        res_value_nxt = '0;
        res_last_nxt  = 1'b1;
        case (cmd_r)
          olad_pkg::CMD_APPEND: begin
            if (count_r == olad_pkg::CNT_W'(olad_pkg::CAPACITY)) begin
              res_status_nxt = olad_pkg::ST_FULL;
            end else begin
              mem_we         = 1'b1;
              mem_waddr      = count_r[olad_pkg::IDX_W-1:0];
              mem_wdata      = val_r;
              count_nxt      = count_r + olad_pkg::CNT_W'(1);
              res_status_nxt = olad_pkg::ST_DONE;
            end
          end
          olad_pkg::CMD_DELETE: res_status_nxt = olad_pkg::ST_NOT_FOUND;
          olad_pkg::CMD_LIST:   res_status_nxt = olad_pkg::ST_EMPTY;
          default:              res_status_nxt = olad_pkg::ST_DONE;
        endcase
      end
      olad_pkg::S_CHECK: begin
        if (cmd_r == olad_pkg::CMD_LIST) begin
          res_status_nxt = olad_pkg::ST_ITEM;
          res_value_nxt  = rd_data_r;
          res_last_nxt   = last_one;
          if (!last_one) idx_nxt = idx_r + olad_pkg::IDX_W'(1);
        end else begin
          res_value_nxt = '0;
          res_last_nxt  = 1'b1;
          if (found_r) begin
            // close the gap: move this entry down one slot
            mem_we    = 1'b1;
            mem_waddr = idx_r - olad_pkg::IDX_W'(1);
            mem_wdata = rd_data_r;
          end
          if (found_r || match) begin
            if (last_one) begin
              count_nxt      = count_r - olad_pkg::CNT_W'(1);
              res_status_nxt = olad_pkg::ST_DONE;
            end else begin
              found_nxt = 1'b1;
              idx_nxt   = idx_r + olad_pkg::IDX_W'(1);
            end
          end else begin
            if (last_one) res_status_nxt = olad_pkg::ST_NOT_FOUND;
            else          idx_nxt        = idx_r + olad_pkg::IDX_W'(1);
          end
        end
      end
      olad_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          out_last_nxt   = res_last_r;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= olad_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    found_r      <= found_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    res_last_r   <= res_last_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

`default_nettype wire

### hdl/olad_chk.sv
// ---------------------------------------------------------------------------
// olad_chk
// Port-level checks for the ordered list core, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module olad_chk (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [olad_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                             out_tlast
);

  logic [olad_pkg::STAT_W-1:0] st;

  assign st = out_tdata[olad_pkg::STAT_W-1:0];

  // a stalled result word holds
  `OLAD_CHECK(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // one command at a time: ready drops right after an accept
  `OLAD_CHECK(a_one_cmd, in_tvalid && in_tready |=> !in_tready)

  // only listed elements may be non-final, and others carry zero data
  `OLAD_CHECK(a_non_item_final, out_tvalid && st != olad_pkg::ST_ITEM |-> out_tlast && out_tdata[olad_pkg::OUT_TDATA_W-1:olad_pkg::STAT_W] == '0)

  // no new command while a non-final result word is still pending
  `OLAD_CHECK(a_ready_idle, out_tvalid && !out_tlast |-> !in_tready)

endmodule

bind ordered_list_append_delete_core olad_chk u_olad_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

### dv/tb_ordered_list_append_delete_core.sv
// ---------------------------------------------------------------------------
// tb_ordered_list_append_delete_core
// Stream-level regression for the ordered list core. A directed opening walks
// the empty-list, duplicate, head/middle/tail delete and spare-code cases.
// Random episodes then fill the list past capacity, drain it and mix commands
// on top of it. A local list predictor checks every result word field by
// field, and both stream sides idle at random.
// ---------------------------------------------------------------------------
module tb_ordered_list_append_delete_core;

  // Command code that the core must treat as a no-op.
  localparam logic [olad_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

  localparam int RANDOM_CMDS    = 135;
  localparam int WATCHDOG_LIMIT = 3000;  // quiet cycles before giving up
  localparam int DRAIN_CYCLES   = 80;    // longer than a full readout
  localparam int HOLDOFF_AT     = 40;    // results seen before the long stall
  localparam int HOLDOFF_LEN    = 250;

  typedef struct packed {
    logic [olad_pkg::CMD_W-1:0] cmd;
    logic [olad_pkg::VAL_W-1:0] value;
  } list_cmd_t;

  typedef struct packed {
    logic [olad_pkg::STAT_W-1:0] status;
    logic [olad_pkg::VAL_W-1:0]  item_value;
    logic                        last;
  } list_resp_t;

  logic                             clk;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [olad_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;   // command, value
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [olad_pkg::OUT_TDATA_W-1:0] out_tdata;         // status, item_value
  logic                             out_tlast;

  // Stimulus and scoreboard state.
  list_cmd_t                  pending_cmds[$];
  list_resp_t                 expected_results[$];
  logic [olad_pkg::VAL_W-1:0] gen_vals[$];    // list contents as the generator sees them
  logic [olad_pkg::VAL_W-1:0] stored_vals[olad_pkg::CAPACITY];
  int               stored_len    = 0;
  int               cmds_total    = 0;
  int               cmds_accepted = 0;
  int               results_seen  = 0;
  int               fail_count    = 0;
  int               quiet_cycles  = 0;

  // Handshake bookkeeping.
  bit               in_taken      = 1'b0;
  int               in_gap        = 0;
  int               in_burst      = 0;
  int               hold_cycles   = 0;
  int               out_burst     = 0;
  bit               holdoff_done  = 1'b0;
  int               rx_roll;
  list_cmd_t        seen_cmd;
  list_resp_t       got_resp;
  list_resp_t       want_resp;
  int               ep_len;

  ordered_list_append_delete_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // -------------------------------------------------------------------------
  // List predictor: apply one accepted command to the local list and queue
  // the result words it must produce.
  // -------------------------------------------------------------------------
  task automatic apply_list_cmd(input list_cmd_t c);
    int i;
    int hit;
    hit = -1;
    case (c.cmd)
      olad_pkg::CMD_APPEND: begin
        if (stored_len >= olad_pkg::CAPACITY) begin
          // full: drop the value, list unchanged
          expected_results.push_back('{olad_pkg::ST_FULL, '0, 1'b1});
        end else begin
          stored_vals[stored_len] = c.value;
          stored_len++;
          expected_results.push_back('{olad_pkg::ST_DONE, '0, 1'b1});
        end
      end
      olad_pkg::CMD_DELETE: begin
        for (i = 0; i < stored_len; i++) begin
          if (hit < 0 && stored_vals[i] == c.value) hit = i;
        end
        if (hit < 0) begin
          expected_results.push_back('{olad_pkg::ST_NOT_FOUND, '0, 1'b1});
        end else begin
          // close the gap behind the first match
          for (i = hit; i + 1 < stored_len; i++) stored_vals[i] = stored_vals[i + 1];
          stored_len--;
          expected_results.push_back('{olad_pkg::ST_DONE, '0, 1'b1});
        end
      end
      olad_pkg::CMD_LIST: begin
        if (stored_len == 0) begin
          expected_results.push_back('{olad_pkg::ST_EMPTY, '0, 1'b1});
        end else begin
          for (i = 0; i < stored_len; i++) begin
            expected_results.push_back('{olad_pkg::ST_ITEM, stored_vals[i],
                                         i + 1 == stored_len});
          end
        end
      end
      default: begin
        // spare code: no-op, single done word
        expected_results.push_back('{olad_pkg::ST_DONE, '0, 1'b1});
      end
    endcase
  endtask

  // Queue one command and track what the list will hold, so that deletes can
  // aim at values that are really there.
  task automatic queue_cmd(input logic [olad_pkg::CMD_W-1:0] c,
                           input logic [olad_pkg::VAL_W-1:0] v);
    list_cmd_t w;
    int i;
    w.cmd   = c;
    w.value = v;
    pending_cmds.push_back(w);
    cmds_total++;
    if (c == olad_pkg::CMD_APPEND && gen_vals.size() < olad_pkg::CAPACITY) begin
      gen_vals.push_back(v);
    end
    if (c == olad_pkg::CMD_DELETE) begin
      for (i = 0; i < gen_vals.size(); i++) begin
        if (gen_vals[i] == v) begin
          gen_vals.delete(i);
          break;
        end
      end
    end
  endtask

  // Favor extremes and a small pool so that duplicates and matches are common.
  function automatic logic [olad_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3:    return $urandom_range(0, 6) - 3;
      default: return $urandom();
    endcase
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // -------------------------------------------------------------------------
  // Input driver: present the next queued word at the falling edge, hold it
  // until taken, then idle for a random gap.
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap--;
      end else if (pending_cmds.size() > 0) begin
        seen_cmd = pending_cmds.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {{(olad_pkg::IN_TDATA_W - olad_pkg::CMD_W - olad_pkg::VAL_W){1'b0}},
                      seen_cmd.value, seen_cmd.cmd};
        // run an occasional burst of words with no gaps at all
        if (in_burst > 0) begin
          in_burst--;
          in_gap = 0;
        end else if ($urandom_range(0, 19) == 0) begin
          in_burst = $urandom_range(10, 30);
          in_gap = 0;
        end else begin
          in_gap = pick_gap();
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Result receiver: random back-pressure, plus one long hold-off so that the
  // core backs up and drops in_tready while the driver keeps offering.
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles--;
    end else if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
      holdoff_done = 1'b1;
      hold_cycles  = HOLDOFF_LEN - 1;
      out_tready <= 1'b0;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (out_burst > 0) begin
        out_burst--;
        out_tready <= 1'b1;
      end else if (rx_roll < 3) begin
        out_burst = $urandom_range(30, 80);
        out_tready <= 1'b1;
      end else if (rx_roll < 65) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        hold_cycles = (rx_roll < 95) ? $urandom_range(0, 2) : $urandom_range(9, 39);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: predict on every accepted input word, check every accepted
  // result word against the oldest expectation.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken     <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_taken     <= in_tvalid && in_tready;
      quiet_cycles <= ((in_tvalid && in_tready) || (out_tvalid && out_tready)) ?
                      0 : quiet_cycles + 1;
      if (in_tvalid && in_tready) begin
        seen_cmd.cmd   = in_tdata[olad_pkg::CMD_W-1:0];
        seen_cmd.value = in_tdata[olad_pkg::CMD_W +: olad_pkg::VAL_W];
        apply_list_cmd(seen_cmd);
        cmds_accepted++;
      end
      if (out_tvalid && out_tready) begin
        got_resp.status     = out_tdata[olad_pkg::STAT_W-1:0];
        got_resp.item_value = out_tdata[olad_pkg::STAT_W +: olad_pkg::VAL_W];
        got_resp.last       = out_tlast;
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result word: status %0d item_value %0d last %0b",
                 got_resp.status, $signed(got_resp.item_value), got_resp.last);
          fail_count++;
        end else begin
          want_resp = expected_results.pop_front();
          if (got_resp.status !== want_resp.status) begin
            $error("status: expected %0d, got %0d", want_resp.status, got_resp.status);
            fail_count++;
          end
          if (got_resp.item_value !== want_resp.item_value) begin
            $error("item_value: expected %0d, got %0d",
                   $signed(want_resp.item_value), $signed(got_resp.item_value));
            fail_count++;
          end
          if (got_resp.last !== want_resp.last) begin
            $error("last: expected %0b, got %0b", want_resp.last, got_resp.last);
            fail_count++;
          end
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // -------------------------------------------------------------------------
  initial begin
    // Directed: empty list, spare code, extremes, duplicates, deletes at
    // head, middle and tail, a miss, and readouts in between.
    queue_cmd(olad_pkg::CMD_LIST,   32'h0000_0000);
    queue_cmd(olad_pkg::CMD_DELETE, 32'h0000_0005);
    queue_cmd(CMD_SPARE,            32'hffff_ffff);
    queue_cmd(olad_pkg::CMD_APPEND, 32'h8000_0000);
    queue_cmd(olad_pkg::CMD_APPEND, 32'h7fff_ffff);
    queue_cmd(olad_pkg::CMD_APPEND, 32'h0000_0000);
    queue_cmd(olad_pkg::CMD_APPEND, 32'hffff_ffff);
    queue_cmd(olad_pkg::CMD_APPEND, 32'h7fff_ffff);
    queue_cmd(olad_pkg::CMD_LIST,   32'hffff_ffff);
    queue_cmd(olad_pkg::CMD_DELETE, 32'h7fff_ffff);   // first of two copies, mid-list
    queue_cmd(olad_pkg::CMD_DELETE, 32'h8000_0000);   // head
    queue_cmd(olad_pkg::CMD_DELETE, 32'h7fff_ffff);   // tail
    queue_cmd(olad_pkg::CMD_DELETE, 32'h0000_3039);   // miss
    queue_cmd(olad_pkg::CMD_LIST,   32'h5555_aaaa);
    queue_cmd(CMD_SPARE,            32'h0000_0000);
    queue_cmd(olad_pkg::CMD_LIST,   32'haaaa_5555);

    // Random episodes; open with a fill so the full case always shows up.
    ep_len = 0;
    while (cmds_total < 16 + RANDOM_CMDS) begin
      case ((ep_len == 0) ? 0 : $urandom_range(0, 9))
        0, 1: begin
          // fill to capacity, push past it, read the full list back
          repeat (olad_pkg::CAPACITY - gen_vals.size() + $urandom_range(1, 3)) begin
            queue_cmd(olad_pkg::CMD_APPEND, pick_value());
          end
          queue_cmd(olad_pkg::CMD_LIST, $urandom());
        end
        2: begin
          // drain in random order down to empty
          while (gen_vals.size() > 0) begin
            queue_cmd(olad_pkg::CMD_DELETE,
                      gen_vals[$urandom_range(0, gen_vals.size() - 1)]);
          end
          queue_cmd(olad_pkg::CMD_LIST, $urandom());
          queue_cmd(olad_pkg::CMD_DELETE, pick_value());
        end
        default: begin
          repeat ($urandom_range(4, 12)) begin
            rx_roll = $urandom_range(0, 19);
            if (rx_roll < 8) begin
              queue_cmd(olad_pkg::CMD_APPEND, pick_value());
            end else if (rx_roll < 13 && gen_vals.size() > 0) begin
              queue_cmd(olad_pkg::CMD_DELETE,
                        gen_vals[$urandom_range(0, gen_vals.size() - 1)]);
            end else if (rx_roll < 15) begin
              queue_cmd(olad_pkg::CMD_DELETE, pick_value());
            end else if (rx_roll < 19) begin
              queue_cmd(olad_pkg::CMD_LIST, $urandom());
            end else begin
              queue_cmd(CMD_SPARE, $urandom());
            end
          end
        end
      endcase
      ep_len++;
    end

    // Hold reset, then release it away from the sampling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Wait for every word to go in and every expected result to come out.
    while ((cmds_accepted < cmds_total || expected_results.size() != 0) &&
           quiet_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk);
    end

    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("ordered_list_append_delete_core regression: fail");
    end else begin
      // let any stray trailing word show up before the verdict
      repeat (DRAIN_CYCLES) @(negedge clk);
      if (fail_count == 0) begin
        $display("ordered_list_append_delete_core regression: pass");
      end else begin
        $display("ordered_list_append_delete_core regression: fail");
      end
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/olad_pkg.sv
hdl/ordered_list_append_delete_core.sv
hdl/olad_chk.sv
dv/tb_ordered_list_append_delete_core.sv
